### rtl/core/csc_pkg.sv
// Shared widths, types and codes for the circle/segment contact pipeline.
package csc_pkg;

  localparam int CoordW  = 16;
  localparam int RadW    = 13;
  localparam int TolW    = 12;
  localparam logic [TolW-1:0] TolReset = TolW'(16);

  localparam int DiffW   = CoordW + 1;
  localparam int ProdW   = 2 * DiffW;
  localparam int DotW    = ProdW + 1;
  localparam int NormW   = DotW - 1;
  localparam int NumW    = DiffW + DotW;
  localparam int DivNW   = NumW + 2;
  localparam int QW      = CoordW + 2;
  localparam int PW      = CoordW + 3;
  localparam int PSqW    = 2 * PW;
  localparam int SqrtInW = 2 * QW;
  localparam int SqrtRW  = SqrtInW + 1;
  localparam int RootW   = QW + 1;
  localparam int ReachW  = RadW + 1;
  localparam int LimW    = 2 * ReachW + 1;
  localparam int Lanes   = 3;

  typedef enum logic [1:0] {
    CauseMiss,
    CauseStart,
    CauseEnd,
    CauseBody
  } cause_e;

  typedef struct packed {
    logic signed [CoordW-1:0] sx, sy, ex, ey, cx, cy;
  } coord_t;

  typedef struct packed {
    coord_t           c;
    logic [LimW-1:0]  lim;
    logic [NormW-1:0] n;
    logic             neg_x;
    logic             neg_y;
    logic             hit_s;
    logic             hit_e;
  } div_side_t;

  typedef struct packed {
    logic hit_s;
    logic hit_e;
    logic nz;
    logic near;
  } sqrt_tail_t;

endpackage

### rtl/core/csc_div.sv
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
module csc_div import csc_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             en_i,
  input  logic             valid_i,
  input  div_side_t        side_i,
  input  logic [DivNW-1:0] numx_i,
  input  logic [DivNW-1:0] numy_i,
  input  logic [DivNW-1:0] den_i,
  output logic             valid_o,
  output div_side_t        side_o,
  output logic [QW-1:0]    qx_o,
  output logic [QW-1:0]    qy_o
);

  logic [QW:0]      vld_q;
  logic [DivNW-1:0] rx_q  [QW+1];
  logic [DivNW-1:0] ry_q  [QW+1];
  logic [DivNW-1:0] den_q [QW+1];
  logic [QW-1:0]    qx_q  [QW+1];
  logic [QW-1:0]    qy_q  [QW+1];
  div_side_t        side_q[QW+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (en_i) begin
      vld_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0]   <= numx_i;
      ry_q[0]   <= numy_i;
      den_q[0]  <= den_i;
      qx_q[0]   <= '0;
      qy_q[0]   <= '0;
      side_q[0] <= side_i;
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [DivNW-1:0] trial;
    logic             selx;
    logic             sely;

    assign trial = den_q[k] << B;
    assign selx  = rx_q[k] >= trial;
    assign sely  = ry_q[k] >= trial;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k+1]   <= selx ? rx_q[k] - trial : rx_q[k];
        ry_q[k+1]   <= sely ? ry_q[k] - trial : ry_q[k];
        qx_q[k+1]   <= qx_q[k] | (QW'(selx) << B);
        qy_q[k+1]   <= qy_q[k] | (QW'(sely) << B);
        den_q[k+1]  <= den_q[k];
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[QW];
  assign side_o  = side_q[QW];
  assign qx_o    = qx_q[QW];
  assign qy_o    = qy_q[QW];

endmodule

### rtl/core/csc_sqrt.sv
// Pipelined square root, three lanes, one root bit per stage, rounded to nearest.
module csc_sqrt import csc_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic               valid_i,
  input  sqrt_tail_t         tail_i,
  input  logic [SqrtInW-1:0] rad_i  [Lanes],
  output logic               valid_o,
  output sqrt_tail_t         tail_o,
  output logic [RootW-1:0]   root_o [Lanes]
);

  logic [QW+1:0]     vld_q;
  logic [SqrtRW-1:0] r_q   [QW+1][Lanes];
  logic [QW-1:0]     q_q   [QW+1][Lanes];
  sqrt_tail_t        tail_q[QW+2];
  logic [RootW-1:0]  root_q[Lanes];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0]    <= 1'b0;
      vld_q[QW+1] <= 1'b0;
    end else if (en_i) begin
      vld_q[0]    <= valid_i;
      vld_q[QW+1] <= vld_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int l = 0; l < Lanes; l++) begin
        r_q[0][l]  <= SqrtRW'(rad_i[l]);
        q_q[0][l]  <= '0;
        root_q[l]  <= RootW'(q_q[QW][l]) + RootW'(r_q[QW][l] > SqrtRW'(q_q[QW][l]));
      end
      tail_q[0]    <= tail_i;
      tail_q[QW+1] <= tail_q[QW];
    end
  end

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [SqrtRW-1:0] trial [Lanes];
    logic [Lanes-1:0]  sel;

    for (genvar l = 0; l < Lanes; l++) begin : g_lane
      assign trial[l] = (SqrtRW'(q_q[k][l]) << (B + 1)) + (SqrtRW'(1) << (2 * B));
      assign sel[l]   = r_q[k][l] >= trial[l];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        for (int l = 0; l < Lanes; l++) begin
          r_q[k+1][l] <= sel[l] ? r_q[k][l] - trial[l] : r_q[k][l];
          q_q[k+1][l] <= q_q[k][l] | (QW'(sel[l]) << B);
        end
        tail_q[k+1] <= tail_q[k];
      end
    end
  end

  assign valid_o = vld_q[QW+1];
  assign tail_o  = tail_q[QW+1];
  assign root_o  = root_q;

endmodule

### rtl/core/circle_segment_collision.sv
// Circle versus line segment contact test, fully pipelined.
// Each query passes through the projection stages, the divider and the square-root pipeline before the result register.
// Throughput: one query per cycle; the whole pipe holds while the output is stalled.
// Reset clears all valid bits and loads the on-segment tolerance with 16.
// The tolerance register is taken from cfg_wdata_i whenever cfg_we_i is high.
module circle_segment_collision import csc_pkg::*; (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic [TolW-1:0]          cfg_wdata_i,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic signed [CoordW-1:0] start_x_i,
  input  logic signed [CoordW-1:0] start_y_i,
  input  logic signed [CoordW-1:0] end_x_i,
  input  logic signed [CoordW-1:0] end_y_i,
  input  logic signed [CoordW-1:0] center_x_i,
  input  logic signed [CoordW-1:0] center_y_i,
  input  logic [RadW-1:0]          radius_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic                     hit_o,
  output logic [1:0]               cause_o
);

  logic            adv;
  logic [TolW-1:0] tol_q;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TolReset;
    end else if (cfg_we_i) begin
      tol_q <= cfg_wdata_i;
    end
  end

  // stage A: differences
  logic                    a_vld_q;
  coord_t                  a_c_q;
  logic signed [DiffW-1:0] a_dsx_q, a_dsy_q, a_dex_q, a_dey_q;
  logic signed [DiffW-1:0] a_lx_q, a_ly_q, a_wx_q, a_wy_q;
  logic [ReachW-1:0]       a_reach_q;

  // stage B: products
  logic                    b_vld_q;
  coord_t                  b_c_q;
  logic signed [DiffW-1:0] b_lx_q, b_ly_q;
  logic [ReachW-1:0]       b_reach_q;
  logic signed [ProdW-1:0] b_ssx_q, b_ssy_q, b_sex_q, b_sey_q;
  logic signed [ProdW-1:0] b_lxx_q, b_lyy_q, b_lwx_q, b_lwy_q;
  logic [2*ReachW-1:0]     b_rr_q;

  // stage C: sums and endpoint tests
  logic                    c_vld_q;
  coord_t                  c_c_q;
  logic signed [DiffW-1:0] c_lx_q, c_ly_q;
  logic [NormW-1:0]        c_n_q;
  logic signed [DotW-1:0]  c_dot_q;
  logic [LimW-1:0]         c_lim_q;
  logic                    c_hs_q, c_he_q;
  logic [DotW-1:0]         ds2, de2, n_full;
  logic [LimW-1:0]         lim;

  // stage D: projection numerators
  logic                    d_vld_q;
  coord_t                  d_c_q;
  logic [NormW-1:0]        d_n_q;
  logic [LimW-1:0]         d_lim_q;
  logic                    d_hs_q, d_he_q;
  logic signed [NumW-1:0]  d_nx_q, d_ny_q;
  logic signed [NumW-1:0]  nx, ny;
  logic [NumW-1:0]         ax, ay;
  div_side_t               div_side_in;

  // divider outputs
  logic                    dv_vld;
  div_side_t               dv_side;
  logic [QW-1:0]           dv_qx, dv_qy;

  // stage G: projected point offsets
  logic                    g_vld_q;
  logic [NormW-1:0]        g_n_q;
  logic [LimW-1:0]         g_lim_q;
  logic                    g_hs_q, g_he_q;
  logic signed [PW-1:0]    g_psx_q, g_psy_q, g_pex_q, g_pey_q, g_pcx_q, g_pcy_q;
  logic signed [PW-1:0]    offx_u, offy_u, offx, offy, px, py;

  // stage H: squares
  logic                    h_vld_q;
  logic [NormW-1:0]        h_n_q;
  logic [LimW-1:0]         h_lim_q;
  logic                    h_hs_q, h_he_q;
  logic signed [PSqW-1:0]  h_psx_q, h_psy_q, h_pex_q, h_pey_q, h_pcx_q, h_pcy_q;
  logic [PSqW-1:0]         ps2, pe2, cp2;
  logic [SqrtInW-1:0]      rad   [Lanes];
  sqrt_tail_t              sq_tail_in;

  // root outputs
  logic                    sq_vld;
  sqrt_tail_t              sq_tail;
  logic [RootW-1:0]        root  [Lanes];
  logic [RootW+1:0]        dsum, len_w, tol_w;
  logic                    on_seg;
  cause_e                  cause;

  logic                    out_vld_q;
  logic                    hit_q;
  cause_e                  cause_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q   <= 1'b0;
      b_vld_q   <= 1'b0;
      c_vld_q   <= 1'b0;
      d_vld_q   <= 1'b0;
      g_vld_q   <= 1'b0;
      h_vld_q   <= 1'b0;
      out_vld_q <= 1'b0;
    end else if (adv) begin
      a_vld_q   <= in_valid_i;
      b_vld_q   <= a_vld_q;
      c_vld_q   <= b_vld_q;
      d_vld_q   <= c_vld_q;
      g_vld_q   <= dv_vld;
      h_vld_q   <= g_vld_q;
      out_vld_q <= sq_vld;
    end
  end

  assign ds2    = DotW'(b_ssx_q) + DotW'(b_ssy_q);
  assign de2    = DotW'(b_sex_q) + DotW'(b_sey_q);
  assign n_full = DotW'(b_lxx_q) + DotW'(b_lyy_q);
  assign lim    = LimW'(b_rr_q) + LimW'(b_reach_q);

  assign nx = c_lx_q * c_dot_q;
  assign ny = c_ly_q * c_dot_q;

  assign ax = d_nx_q[NumW-1] ? NumW'(-d_nx_q) : NumW'(d_nx_q);
  assign ay = d_ny_q[NumW-1] ? NumW'(-d_ny_q) : NumW'(d_ny_q);

  always_comb begin
    div_side_in       = '0;
    div_side_in.c     = d_c_q;
    div_side_in.lim   = d_lim_q;
    div_side_in.n     = d_n_q;
    div_side_in.neg_x = d_nx_q[NumW-1];
    div_side_in.neg_y = d_ny_q[NumW-1];
    div_side_in.hit_s = d_hs_q;
    div_side_in.hit_e = d_he_q;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      a_c_q.sx  <= start_x_i;
      a_c_q.sy  <= start_y_i;
      a_c_q.ex  <= end_x_i;
      a_c_q.ey  <= end_y_i;
      a_c_q.cx  <= center_x_i;
      a_c_q.cy  <= center_y_i;
      a_dsx_q   <= DiffW'(start_x_i) - DiffW'(center_x_i);
      a_dsy_q   <= DiffW'(start_y_i) - DiffW'(center_y_i);
      a_dex_q   <= DiffW'(end_x_i) - DiffW'(center_x_i);
      a_dey_q   <= DiffW'(end_y_i) - DiffW'(center_y_i);
      a_lx_q    <= DiffW'(end_x_i) - DiffW'(start_x_i);
      a_ly_q    <= DiffW'(end_y_i) - DiffW'(start_y_i);
      a_wx_q    <= DiffW'(center_x_i) - DiffW'(start_x_i);
      a_wy_q    <= DiffW'(center_y_i) - DiffW'(start_y_i);
      a_reach_q <= {radius_i, 1'b0};

      b_c_q     <= a_c_q;
      b_lx_q    <= a_lx_q;
      b_ly_q    <= a_ly_q;
      b_reach_q <= a_reach_q;
      b_ssx_q   <= a_dsx_q * a_dsx_q;
      b_ssy_q   <= a_dsy_q * a_dsy_q;
      b_sex_q   <= a_dex_q * a_dex_q;
      b_sey_q   <= a_dey_q * a_dey_q;
      b_lxx_q   <= a_lx_q * a_lx_q;
      b_lyy_q   <= a_ly_q * a_ly_q;
      b_lwx_q   <= a_lx_q * a_wx_q;
      b_lwy_q   <= a_ly_q * a_wy_q;
      b_rr_q    <= a_reach_q * a_reach_q;

      c_c_q     <= b_c_q;
      c_lx_q    <= b_lx_q;
      c_ly_q    <= b_ly_q;
      c_n_q     <= n_full[NormW-1:0];
      c_dot_q   <= DotW'(b_lwx_q) + DotW'(b_lwy_q);
      c_lim_q   <= lim;
      c_hs_q    <= ds2 <= DotW'(lim);
      c_he_q    <= de2 <= DotW'(lim);

      d_c_q     <= c_c_q;
      d_n_q     <= c_n_q;
      d_lim_q   <= c_lim_q;
      d_hs_q    <= c_hs_q;
      d_he_q    <= c_he_q;
      d_nx_q    <= nx;
      d_ny_q    <= ny;
    end
  end

  csc_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (d_vld_q),
    .side_i  (div_side_in),
    .numx_i  ({ax, 1'b0} + DivNW'(d_n_q)),
    .numy_i  ({ay, 1'b0} + DivNW'(d_n_q)),
    .den_i   (DivNW'({d_n_q, 1'b0})),
    .valid_o (dv_vld),
    .side_o  (dv_side),
    .qx_o    (dv_qx),
    .qy_o    (dv_qy)
  );

  assign offx_u = PW'(dv_qx);
  assign offy_u = PW'(dv_qy);
  assign offx   = dv_side.neg_x ? -offx_u : offx_u;
  assign offy   = dv_side.neg_y ? -offy_u : offy_u;
  assign px     = PW'($signed(dv_side.c.sx)) + offx;
  assign py     = PW'($signed(dv_side.c.sy)) + offy;

  assign ps2 = PSqW'(h_psx_q) + PSqW'(h_psy_q);
  assign pe2 = PSqW'(h_pex_q) + PSqW'(h_pey_q);
  assign cp2 = PSqW'(h_pcx_q) + PSqW'(h_pcy_q);

  assign rad[0] = SqrtInW'(h_n_q);
  assign rad[1] = ps2[SqrtInW-1:0];
  assign rad[2] = pe2[SqrtInW-1:0];

  always_comb begin
    sq_tail_in       = '0;
    sq_tail_in.hit_s = h_hs_q;
    sq_tail_in.hit_e = h_he_q;
    sq_tail_in.nz    = h_n_q != '0;
    sq_tail_in.near  = cp2 <= PSqW'(h_lim_q);
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      g_n_q   <= dv_side.n;
      g_lim_q <= dv_side.lim;
      g_hs_q  <= dv_side.hit_s;
      g_he_q  <= dv_side.hit_e;
      g_psx_q <= offx;
      g_psy_q <= offy;
      g_pex_q <= px - PW'($signed(dv_side.c.ex));
      g_pey_q <= py - PW'($signed(dv_side.c.ey));
      g_pcx_q <= PW'($signed(dv_side.c.cx)) - px;
      g_pcy_q <= PW'($signed(dv_side.c.cy)) - py;

      h_n_q   <= g_n_q;
      h_lim_q <= g_lim_q;
      h_hs_q  <= g_hs_q;
      h_he_q  <= g_he_q;
      h_psx_q <= g_psx_q * g_psx_q;
      h_psy_q <= g_psy_q * g_psy_q;
      h_pex_q <= g_pex_q * g_pex_q;
      h_pey_q <= g_pey_q * g_pey_q;
      h_pcx_q <= g_pcx_q * g_pcx_q;
      h_pcy_q <= g_pcy_q * g_pcy_q;
    end
  end

  csc_sqrt u_sqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (h_vld_q),
    .tail_i  (sq_tail_in),
    .rad_i   (rad),
    .valid_o (sq_vld),
    .tail_o  (sq_tail),
    .root_o  (root)
  );

  assign dsum   = (RootW+2)'(root[1]) + (RootW+2)'(root[2]);
  assign len_w  = (RootW+2)'(root[0]);
  assign tol_w  = (RootW+2)'(tol_q);
  assign on_seg = (dsum + tol_w >= len_w) && (dsum <= len_w + tol_w);

  always_comb begin
    if (sq_tail.hit_s) begin
      cause = CauseStart;
    end else if (sq_tail.hit_e) begin
      cause = CauseEnd;
    end else if (sq_tail.nz && on_seg && sq_tail.near) begin
      cause = CauseBody;
    end else begin
      cause = CauseMiss;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit_q   <= cause != CauseMiss;
      cause_q <= cause;
    end
  end

  assign out_valid_o = out_vld_q;
  assign hit_o       = hit_q;
  assign cause_o     = cause_q;

endmodule

### test/circle_segment_collision_test.sv
// Self-checking testbench for the circle versus segment contact pipeline.
`timescale 1ns / 100ps

module circle_segment_collision_test;
  import csc_pkg::*;

  localparam int Latency = 46;

  typedef struct packed {
    logic   hit;
    cause_e cause;
  } contact_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [TolW-1:0] cfg_wdata_i = '0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  logic signed [CoordW-1:0] start_x_i = '0, start_y_i = '0, end_x_i = '0, end_y_i = '0;
  logic signed [CoordW-1:0] center_x_i = '0, center_y_i = '0;
  logic [RadW-1:0] radius_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  logic hit_o;
  logic [1:0] cause_o;

  contact_t contact_q[$];
  logic [TolW-1:0] tolerance = TolReset;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int mismatches = 0;

  circle_segment_collision DUT (.*);

  always #4 clk_i = ~clk_i;

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < recv_stall_pct);

  function automatic longint unsigned root_round(longint unsigned v);
    longint unsigned r = 0;
    longint unsigned x = v;
    longint unsigned b = 64'h4000_0000_0000_0000;
    while (b > x) b >>= 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    if (x > r) r++;
    return r;
  endfunction

  function automatic longint distance(longint dx, longint dy);
    return longint'(root_round(longint'(dx * dx + dy * dy)));
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint a = num < 0 ? -num : num;
    longint q = (2 * a + den) / (2 * den);
    return num < 0 ? -q : q;
  endfunction

  function automatic contact_t predict_contact(longint sx, longint sy, longint ex, longint ey,
                                               longint cx, longint cy, longint rad);
    contact_t c;
    longint reach = 2 * rad;
    longint lx = ex - sx, ly = ey - sy;
    longint n = lx * lx + ly * ly;
    longint dp, px, py, len, sum, tol;
    c.hit = 1'b0;
    c.cause = CauseMiss;
    tol = longint'(tolerance);
    if (distance(sx - cx, sy - cy) <= reach) begin
      c.hit = 1'b1;
      c.cause = CauseStart;
    end else if (distance(ex - cx, ey - cy) <= reach) begin
      c.hit = 1'b1;
      c.cause = CauseEnd;
    end else if (n != 0) begin
      dp = lx * (cx - sx) + ly * (cy - sy);
      px = sx + round_div(lx * dp, n);
      py = sy + round_div(ly * dp, n);
      len = longint'(root_round(n));
      sum = distance(px - sx, py - sy) + distance(px - ex, py - ey);
      if (sum >= len - tol && sum <= len + tol && distance(cx - px, cy - py) <= reach) begin
        c.hit = 1'b1;
        c.cause = CauseBody;
      end
    end
    return c;
  endfunction

  always @(posedge clk_i) begin
    if (out_valid_o && !out_stall_i) begin
      if (contact_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result hit=%0d cause=%0d", hit_o, cause_o);
      end else begin
        if (hit_o !== contact_q[0].hit || cause_o !== contact_q[0].cause) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected hit=%0d cause=%0d, got hit=%0d cause=%0d",
                     contact_q[0].hit, contact_q[0].cause, hit_o, cause_o);
        end
        void'(contact_q.pop_front());
      end
    end
  end

  task automatic send_query(longint sx, longint sy, longint ex, longint ey,
                            longint cx, longint cy, longint rad);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    start_x_i <= sx[15:0];
    start_y_i <= sy[15:0];
    end_x_i <= ex[15:0];
    end_y_i <= ey[15:0];
    center_x_i <= cx[15:0];
    center_y_i <= cy[15:0];
    radius_i <= rad[12:0];
    do @(posedge clk_i); while (in_stall_o);
    contact_q.push_back(predict_contact(sx, sy, ex, ey, cx, cy, rad));
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (contact_q.size() != 0) @(posedge clk_i);
    repeat (Latency + 10) @(posedge clk_i);
  endtask

  task automatic write_tolerance(logic [TolW-1:0] value);
    drain();
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    tolerance = value;
    @(posedge clk_i);
  endtask

  function automatic longint clamp16(longint v);
    return v > 32767 ? 32767 : (v < -32768 ? -32768 : v);
  endfunction

  task automatic send_random(int count);
    longint sx, sy, ex, ey, cx, cy, rad, s, k;
    repeat (count) begin
      if ($urandom_range(9) < 2) begin
        send_query($signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                   $signed(16'($urandom)), $signed(16'($urandom)), $signed(16'($urandom)),
                   $urandom_range(8191));
      end else begin
        case ($urandom_range(2))
          0: s = 64;
          1: s = 2048;
          default: s = 32767;
        endcase
        sx = $signed(16'($urandom));
        sy = $signed(16'($urandom));
        ex = ($urandom_range(19) == 0) ? sx : clamp16(sx + $signed(32'($urandom_range(2 * s)))
                                                       - s);
        ey = clamp16(sy + $signed(32'($urandom_range(2 * s))) - s);
        if (ex == sx && $urandom_range(1)) ey = sy;
        k = $urandom_range(8);
        cx = clamp16(sx + (ex - sx) * k / 8 + $signed(32'($urandom_range(s))) - s / 2);
        cy = clamp16(sy + (ey - sy) * k / 8 + $signed(32'($urandom_range(s))) - s / 2);
        rad = $urandom_range(s > 8191 ? 8191 : s);
        if ($urandom_range(3) == 0) rad = rad / 8;
        send_query(sx, sy, ex, ey, cx, cy, rad);
      end
    end
  endtask

  task automatic test_directed;
    send_query(-32768, -32768, 32767, 32767, 0, 0, 0);
    send_query(32767, -32768, -32768, 32767, -32768, 32767, 8191);
    send_query(0, 0, 1000, 0, 10, 0, 10);
    send_query(0, 0, 1000, 0, 995, 0, 10);
    send_query(0, 0, 20, 0, 10, 0, 8);
    send_query(0, 0, 1000, 0, 500, 30, 15);
    send_query(0, 0, 1000, 0, 500, 30, 14);
    send_query(100, 100, 100, 100, 500, 500, 5);
    send_query(100, 100, 100, 100, 100, 100, 0);
    send_query(0, 0, 1000, 0, 2000, 0, 400);
    send_query(0, 0, 1000, 1000, 500, 520, 20);
    send_query(-32768, 0, 32767, 0, 0, -32768, 8191);
    send_query(32767, 32767, 32767, 32767, -32768, -32768, 8191);
    write_tolerance(0);
    send_query(0, 0, 1000, 7, 500, 40, 25);
    send_query(0, 0, 1000, 0, 1200, 0, 150);
    write_tolerance(4095);
    send_query(0, 0, 1000, 0, 2000, 0, 400);
    send_query(0, 0, 30, 0, -500, 0, 200);
    send_query(0, 0, 1000, 0, 1500, 300, 200);
  endtask

  task automatic test_random_no_idle;
    write_tolerance(16);
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_random(400);
  endtask

  task automatic test_random_sender_idle;
    write_tolerance(0);
    send_idle_pct = 80;
    recv_stall_pct = 0;
    send_random(400);
  endtask

  task automatic test_random_receiver_stall;
    write_tolerance(4095);
    send_idle_pct = 0;
    recv_stall_pct = 80;
    send_random(400);
  endtask

  task automatic test_random_both_idle;
    write_tolerance(TolW'($urandom_range(64)));
    send_idle_pct = 34;
    recv_stall_pct = 34;
    send_random(350);
  endtask

  task automatic test_pipeline_drain;
    send_idle_pct = 0;
    recv_stall_pct = 34;
    repeat (6) begin
      send_random(8);
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while (contact_q.size() != 0) @(posedge clk_i);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_no_idle();
    test_random_sender_idle();
    test_random_receiver_stall();
    test_random_both_idle();
    test_pipeline_drain();
    drain();
    if (mismatches == 0 && contact_q.size() == 0) begin
      $display("circle_segment_collision_test: PASS");
    end else begin
      $display("circle_segment_collision_test: FAIL");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("circle_segment_collision_test: FAIL");
    $finish;
  end

endmodule
